@@ rtl/sit_pkg.sv @@
// Shared constants and types for the signature intern table.
// No dependencies; imported by the table and its checker.
package sit_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int MAX_ARGS    = 8;

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = IDX_W + 1;
    localparam int BYTE_W  = 8;
    localparam int NARGS_W = 4;
    localparam int OUT_W   = 8;
    localparam int HDR_W   = 2 * BYTE_W + NARGS_W + 1;
    localparam int ARGS_W  = BYTE_W * MAX_ARGS;
    localparam int ENTRY_W = HDR_W + ARGS_W;

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [OUT_W-1:0]   index_t;

endpackage

@@ rtl/signature_intern_table.sv @@
// Signature intern table: lookup-or-insert over a single entry memory.
// Depends on sit_pkg.
//
// Usage: a key request is presented on key_valid/key_ready with its fields
// call_conv, ret_type, num_args, variadic and arg_type_0..7. Only the first
// num_args argument bytes (at most MAX_ARGS) take part; the rest are ignored.
// Each key yields one result request on result_valid/result_ready carrying
// entry_index and table_full.
// The stored entries are scanned in insertion order, one memory read per
// cycle with the compare in the cycle after each read. The next key can be
// taken in the cycle after the result is loaded. The search time is set by
// the single read port of the entry memory. One key is in work at a time.
// A new key is appended at the current count; when the table is full it is
// dropped and answered with index 0 and table_full set.
// Reset empties the table at once by clearing the entry count; the memory
// itself is not cleared. If the receiver stalls, the result is held in the
// output register and the block may already take and search the next key.
module signature_intern_table
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   key_valid,
    output logic                   key_ready,
    input  logic [7:0]             call_conv,
    input  logic [7:0]             ret_type,
    input  logic [3:0]             num_args,
    input  logic                   variadic,
    input  logic [7:0]             arg_type_0,
    input  logic [7:0]             arg_type_1,
    input  logic [7:0]             arg_type_2,
    input  logic [7:0]             arg_type_3,
    input  logic [7:0]             arg_type_4,
    input  logic [7:0]             arg_type_5,
    input  logic [7:0]             arg_type_6,
    input  logic [7:0]             arg_type_7,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [7:0]             entry_index,
    output logic                   table_full
);
    import sit_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DONE   = 2'd2;

    logic [1:0]  state_reg, state_next;
    entry_t      key_reg, key_next;
    count_t      count_reg, count_next;
    count_t      scan_reg, scan_next;
    logic        pend_reg, pend_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    index_t      fin_idx_reg, fin_idx_next;
    logic        fin_full_reg, fin_full_next;
    logic        res_valid_reg, res_valid_next;
    index_t      res_idx_reg, res_idx_next;
    logic        res_full_reg, res_full_next;

    entry_t      mem [TABLE_DEPTH];
    entry_t      mem_q;
    logic        rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr;

    byte_t       arg_in [8];
    entry_t      key_in;
    logic        hit;

    always_comb
    begin
        arg_in[0] = arg_type_0;
        arg_in[1] = arg_type_1;
        arg_in[2] = arg_type_2;
        arg_in[3] = arg_type_3;
        arg_in[4] = arg_type_4;
        arg_in[5] = arg_type_5;
        arg_in[6] = arg_type_6;
        arg_in[7] = arg_type_7;
        key_in = '0;
        key_in[HDR_W-1:0] = {variadic, num_args, ret_type, call_conv};
        for (int k = 0; k < MAX_ARGS; k++)
        begin
            if (NARGS_W'(k) < num_args)
            begin
                key_in[HDR_W + BYTE_W*k +: BYTE_W] = arg_in[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= key_reg;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    assign hit     = pend_reg && (mem_q == key_reg);
    assign rd_addr = scan_reg[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        pend_next      = pend_reg;
        pidx_next      = pidx_reg;
        fin_idx_next   = fin_idx_reg;
        fin_full_next  = fin_full_reg;
        res_valid_next = res_valid_reg;
        res_idx_next   = res_idx_reg;
        res_full_next  = res_full_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;

        if (res_valid_reg && result_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (key_valid)
                begin
                    key_next   = key_in;
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    fin_idx_next  = OUT_W'(pidx_reg);
                    fin_full_next = 1'b0;
                    pend_next     = 1'b0;
                    state_next    = S_DONE;
                end
                else if (scan_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = scan_reg[IDX_W-1:0];
                    scan_next = scan_reg + 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                    if (count_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        fin_idx_next  = '0;
                        fin_full_next = 1'b1;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        fin_idx_next  = OUT_W'(count_reg);
                        fin_full_next = 1'b0;
                        count_next    = count_reg + 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_valid_next = 1'b1;
                    res_idx_next   = fin_idx_reg;
                    res_full_next  = fin_full_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        scan_reg     <= scan_next;
        pidx_reg     <= pidx_next;
        fin_idx_reg  <= fin_idx_next;
        fin_full_reg <= fin_full_next;
        res_idx_reg  <= res_idx_next;
        res_full_reg <= res_full_next;
    end

    assign key_ready    = (state_reg == S_IDLE);
    assign result_valid = res_valid_reg;
    assign entry_index  = res_idx_reg;
    assign table_full   = res_full_reg;

endmodule

@@ rtl/sit_checker.sv @@
// Port-level checks for the signature intern table, with the bind that
// attaches them to signature_intern_table. Depends on the top level's ports.
module sit_port_checks
(
    input logic       clk,
    input logic       rst_n,
    input logic       key_valid,
    input logic       key_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] entry_index,
    input logic       table_full
);

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && table_full |-> entry_index == 8'd0)
        else $error("full result carries a non-zero index");

    a_one_key: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key_ready |=> !key_ready)
        else $error("second key taken while a search is in progress");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("stalled result request withdrawn");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(entry_index) && $stable(table_full))
        else $error("stalled result request changed");

endmodule

bind signature_intern_table sit_port_checks u_sit_port_checks
(
    .clk          (clk),
    .rst_n        (rst_n),
    .key_valid    (key_valid),
    .key_ready    (key_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .entry_index  (entry_index),
    .table_full   (table_full)
);

@@ sim/sit_checker.sv @@
// Checker for the signature intern table: watches the key and result channels,
// keeps its own copy of the table to predict each answer and compares it.
// Depends on sit_pkg.
module sit_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       key_valid,
    input  logic       key_ready,
    input  logic [7:0] call_conv,
    input  logic [7:0] ret_type,
    input  logic [3:0] num_args,
    input  logic       variadic,
    input  logic [7:0] arg_type_0,
    input  logic [7:0] arg_type_1,
    input  logic [7:0] arg_type_2,
    input  logic [7:0] arg_type_3,
    input  logic [7:0] arg_type_4,
    input  logic [7:0] arg_type_5,
    input  logic [7:0] arg_type_6,
    input  logic [7:0] arg_type_7,
    input  logic       result_valid,
    input  logic       result_ready,
    input  logic [7:0] entry_index,
    input  logic       table_full,
    output int         fail_count,
    output int         outstanding,
    output int         stored_total,
    output int         hit_total,
    output int         refused_total
);
    import sit_pkg::*;

    typedef struct packed {
        index_t index;
        logic   full;
    } intern_result_t;

    logic [HDR_W-1:0]  stored_header [TABLE_DEPTH];
    logic [ARGS_W-1:0] stored_args   [TABLE_DEPTH];
    intern_result_t    expected_results [$];

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [HDR_W-1:0]  hdr;
        logic [ARGS_W-1:0] live_args;
        logic [63:0]       raw_args;
        intern_result_t    want;
        intern_result_t    got;
        bit                found;
        if (!rst_n)
        begin
            stored_total  = 0;
            hit_total     = 0;
            refused_total = 0;
            fail_count    = 0;
            outstanding   = 0;
            expected_results.delete();
        end
        else
        begin
            if (key_valid && key_ready)
            begin
                raw_args = {arg_type_7, arg_type_6, arg_type_5, arg_type_4,
                            arg_type_3, arg_type_2, arg_type_1, arg_type_0};
                hdr = {variadic, num_args, ret_type, call_conv};
                live_args = '0;
                for (int k = 0; k < MAX_ARGS; k++)
                    if (k < int'(num_args))
                        live_args[BYTE_W*k +: BYTE_W] = raw_args[BYTE_W*k +: BYTE_W];
                found = 1'b0;
                want  = '0;
                for (int i = 0; i < stored_total && !found; i++)
                begin
                    if (stored_header[i] == hdr && stored_args[i] == live_args)
                    begin
                        want.index = index_t'(i);
                        found      = 1'b1;
                    end
                end
                if (found)
                    hit_total++;
                else if (stored_total >= TABLE_DEPTH)
                begin
                    want.full = 1'b1;
                    refused_total++;
                end
                else
                begin
                    stored_header[stored_total] = hdr;
                    stored_args[stored_total]   = live_args;
                    want.index = index_t'(stored_total);
                    stored_total++;
                end
                expected_results.push_back(want);
            end
            if (result_valid && result_ready)
            begin
                got.index = entry_index;
                got.full  = table_full;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: result with no request outstanding: index %0d full %0b",
                                 got.index, got.full);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.index !== want.index || got.full !== want.full)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("ERROR: expected index %0d full %0b, got index %0d full %0b",
                                     want.index, want.full, got.index, got.full);
                    end
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

@@ sim/tb_signature_intern_table.sv @@
// Testbench top for the signature intern table: drives key requests in bursts,
// stalls the result side and gives the verdict from the checker's counts.
// Depends on sit_pkg, sit_checker and the signature_intern_table RTL.
module tb_signature_intern_table;

    import sit_pkg::*;

    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int HOLD_CYCLES  = 1000;

    typedef logic [3:0] nargs_t;

    typedef struct packed {
        byte_t       conv;
        byte_t       ret;
        nargs_t      nargs;
        logic        var_flag;
        logic [63:0] args;
    } sig_key_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       key_valid    = 1'b0;
    logic [7:0] call_conv    = 8'h00;
    logic [7:0] ret_type     = 8'h00;
    logic [3:0] num_args     = 4'h0;
    logic       variadic     = 1'b0;
    logic [7:0] arg_type_0   = 8'h00;
    logic [7:0] arg_type_1   = 8'h00;
    logic [7:0] arg_type_2   = 8'h00;
    logic [7:0] arg_type_3   = 8'h00;
    logic [7:0] arg_type_4   = 8'h00;
    logic [7:0] arg_type_5   = 8'h00;
    logic [7:0] arg_type_6   = 8'h00;
    logic [7:0] arg_type_7   = 8'h00;
    logic       result_ready = 1'b0;
    logic       key_ready;
    logic       result_valid;
    logic [7:0] entry_index;
    logic       table_full;

    int fail_count;
    int outstanding;
    int stored_total;
    int hit_total;
    int refused_total;
    int cycle_count = 0;

    sig_key_t key_plan [$];

    signature_intern_table DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_ready    (key_ready),
        .call_conv    (call_conv),
        .ret_type     (ret_type),
        .num_args     (num_args),
        .variadic     (variadic),
        .arg_type_0   (arg_type_0),
        .arg_type_1   (arg_type_1),
        .arg_type_2   (arg_type_2),
        .arg_type_3   (arg_type_3),
        .arg_type_4   (arg_type_4),
        .arg_type_5   (arg_type_5),
        .arg_type_6   (arg_type_6),
        .arg_type_7   (arg_type_7),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .entry_index  (entry_index),
        .table_full   (table_full)
    );

    sit_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .key_valid     (key_valid),
        .key_ready     (key_ready),
        .call_conv     (call_conv),
        .ret_type      (ret_type),
        .num_args      (num_args),
        .variadic      (variadic),
        .arg_type_0    (arg_type_0),
        .arg_type_1    (arg_type_1),
        .arg_type_2    (arg_type_2),
        .arg_type_3    (arg_type_3),
        .arg_type_4    (arg_type_4),
        .arg_type_5    (arg_type_5),
        .arg_type_6    (arg_type_6),
        .arg_type_7    (arg_type_7),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .entry_index   (entry_index),
        .table_full    (table_full),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .stored_total  (stored_total),
        .hit_total     (hit_total),
        .refused_total (refused_total)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, outstanding);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic sig_key_t make_key(input byte_t conv, input byte_t ret, input int nargs,
                                          input logic var_flag, input logic [63:0] args);
        sig_key_t k;
        k.conv     = conv;
        k.ret      = ret;
        k.nargs    = nargs_t'(nargs);
        k.var_flag = var_flag;
        k.args     = args;
        return k;
    endfunction

    task automatic offer_key(input sig_key_t k);
        key_valid  <= 1'b1;
        call_conv  <= k.conv;
        ret_type   <= k.ret;
        num_args   <= k.nargs;
        variadic   <= k.var_flag;
        arg_type_0 <= k.args[7:0];
        arg_type_1 <= k.args[15:8];
        arg_type_2 <= k.args[23:16];
        arg_type_3 <= k.args[31:24];
        arg_type_4 <= k.args[39:32];
        arg_type_5 <= k.args[47:40];
        arg_type_6 <= k.args[55:48];
        arg_type_7 <= k.args[63:56];
        @(posedge clk);
        while (!key_ready)
            @(posedge clk);
    endtask

    // The receiver mixes free-running, random and sparse acceptance with
    // fully stalled stretches, and once holds off long enough to back up the table.
    initial
    begin : receiver
        int delivered;
        int stretch;
        int mode;
        bit held;
        delivered = 0;
        held      = 1'b0;
        wait (rst_n);
        forever
        begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(10, 200);
            for (int c = 0; c < stretch; c++)
            begin
                @(posedge clk);
                if (result_valid && result_ready)
                    delivered++;
                if (!held && delivered >= 30)
                begin
                    held = 1'b1;
                    result_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                else
                begin
                    case (mode)
                        0:       result_ready <= 1'b1;
                        1:       result_ready <= ($urandom_range(0, 1) != 0);
                        2:       result_ready <= ($urandom_range(0, 4) == 0);
                        default: result_ready <= 1'b0;
                    endcase
                end
            end
        end
    end

    initial
    begin : sender
        sig_key_t k;
        int       roll;
        int       burst;
        int       next;

        // Extremes, the variadic wrapper, counts above the limit and
        // argument bytes beyond the count.
        key_plan.push_back(make_key(8'h00, 8'h00, 0, 1'b0, 64'h0));
        key_plan.push_back(make_key(8'h00, 8'h00, 0, 1'b0, {64{1'b1}}));
        key_plan.push_back(make_key(8'hFF, 8'hFF, 8, 1'b1, {64{1'b1}}));
        key_plan.push_back(make_key(8'hFF, 8'hFF, 15, 1'b1, {64{1'b1}}));
        key_plan.push_back(make_key(8'hFF, 8'hFF, 9, 1'b1, {64{1'b1}}));
        key_plan.push_back(make_key(8'hFF, 8'hFF, 15, 1'b1, {64{1'b1}}));
        key_plan.push_back(make_key(8'h00, 8'h00, 0, 1'b1, 64'h0));
        key_plan.push_back(make_key(8'h00, 8'h00, 0, 1'b1, 64'h1234_5678_9ABC_DEF0));
        key_plan.push_back(make_key(8'h10, 8'h20, 3, 1'b0, 64'hDEAD_BEEF_CA03_0201));
        key_plan.push_back(make_key(8'h10, 8'h20, 3, 1'b0, 64'h0000_0000_0003_0201));
        key_plan.push_back(make_key(8'h10, 8'h20, 4, 1'b0, 64'h0000_0000_0003_0201));
        key_plan.push_back(make_key(8'h55, 8'hAA, 5, 1'b0, 64'h5555_5555_5555_5555));
        key_plan.push_back(make_key(8'hAA, 8'h55, 10, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA));
        key_plan.push_back(make_key(8'h80, 8'h01, 1, 1'b0, 64'h80));
        key_plan.push_back(make_key(8'h01, 8'h80, 2, 1'b1, 64'h0180));
        key_plan.push_back(make_key(8'h00, 8'h00, 8, 1'b0, 64'h0));
        key_plan.push_back(make_key(8'hFF, 8'hFF, 8, 1'b1, {64{1'b1}}));
        key_plan.push_back(make_key(8'h00, 8'h00, 0, 1'b0, 64'h0));

        // Fresh keys fill the table part way through, so the later requests
        // mix hits with refusals against a full table.
        repeat (530)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
            begin
                k = key_plan[$urandom_range(0, key_plan.size() - 1)];
                for (int b = 0; b < 8; b++)
                    if (b >= int'(k.nargs))
                        k.args[8*b +: 8] = byte_t'($urandom_range(0, 255));
            end
            else if (roll < 40)
            begin
                k = key_plan[$urandom_range(0, key_plan.size() - 1)];
                case ($urandom_range(0, 2))
                    0:       k.var_flag = ~k.var_flag;
                    1:       k.nargs = k.nargs + nargs_t'(1);
                    default: k.conv = k.conv ^ byte_t'(1 << $urandom_range(0, 7));
                endcase
            end
            else
            begin
                k.conv     = ($urandom_range(0, 4) == 0) ? 8'h00
                                                         : byte_t'($urandom_range(0, 255));
                k.ret      = byte_t'($urandom_range(0, 255));
                k.nargs    = ($urandom_range(0, 6) == 0) ? nargs_t'($urandom_range(9, 15))
                                                         : nargs_t'($urandom_range(0, 8));
                k.var_flag = ($urandom_range(0, 1) != 0);
                k.args     = {$urandom(), $urandom()};
            end
            key_plan.push_back(k);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        next = 0;
        while (next < key_plan.size())
        begin
            burst = $urandom_range(1, 16);
            for (int b = 0; b < burst && next < key_plan.size(); b++)
            begin
                offer_key(key_plan[next]);
                next++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                key_valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
        key_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 16) @(posedge clk);

        $display("Sent %0d key requests: %0d new entries, %0d found present, %0d refused as full.",
                 key_plan.size(), stored_total, hit_total, refused_total);
        $display("The table ended with %0d of %0d entries; the result side once held off %0d cycles.",
                 stored_total, TABLE_DEPTH, HOLD_CYCLES);
        if (fail_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
